>>> rtl/core/wsu_pkg.sv
`timescale 1ns / 1ps

package wsu_pkg;

   // Width of one stream item and of the decoded lengths.
   localparam int ByteWidth    = 8;
   localparam int LengthWidth  = 64;
   localparam int KeyWidth     = 32;
   localparam int HdrWidth     = 4;
   localparam int CountWidth   = 3;

   // Result bus: data byte, payload length and header length, padded to bytes.
   localparam int RspDataWidth = 80;

   // Length field codes of the second header byte.
   localparam logic [6:0] Len7Mask   = 7'h7F;
   localparam logic [6:0] LenExt16   = 7'd126;
   localparam logic [6:0] LenExt64   = 7'd127;

   // Header sizes including the four mask key bytes.
   localparam logic [HdrWidth-1:0] HdrShort = 4'd6;
   localparam logic [HdrWidth-1:0] HdrExt16 = 4'd8;
   localparam logic [HdrWidth-1:0] HdrExt64 = 4'd14;

   // Extended length byte counts, and the mask key byte count.
   localparam logic [CountWidth-1:0] Ext16Bytes = 3'd2;
   localparam logic [CountWidth-1:0] Ext64Bytes = 3'd0; // eight bytes wrap to zero
   localparam logic [CountWidth-1:0] KeyBytes   = 3'd4;

   // Frame parser phases, one-hot.
   typedef enum logic [4:0] {
      PH_FIRST   = 5'b00001,
      PH_LEN     = 5'b00010,
      PH_EXT     = 5'b00100,
      PH_MASK    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // One unmasked payload item.
   typedef struct packed {
      logic [ByteWidth-1:0]   data_byte;
      logic                   last_of_frame;
      logic [LengthWidth-1:0] payload_length;
      logic [HdrWidth-1:0]    header_length;
   } result_type;

   // Input register towards the parser.
   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] stream_byte;
   } held_item_type;

endpackage

>>> rtl/core/wsu_in_stage.sv
`timescale 1ns / 1ps

module wsu_in_stage
   import wsu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ByteWidth-1:0] req_tdata,
   input  logic                 advance,
   output held_item_type        held
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;

   // The register takes a new item when empty or when its item moves on.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held.valid       = valid_ff;
   assign held.stream_byte = byte_ff;

endmodule

>>> rtl/core/wsu_parser.sv
`timescale 1ns / 1ps

module wsu_parser
   import wsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  held_item_type held,
   input  logic          advance,
   output logic          has_result,
   output result_type    result
);

   phase_type               phase_ff,      phase_in;
   logic [CountWidth-1:0]   count_ff,      count_in;
   logic [LengthWidth-1:0]  length_ff,     length_in;
   logic [KeyWidth-1:0]     key_ff,        key_in;
   logic [LengthWidth-1:0]  index_ff,      index_in;
   logic [HdrWidth-1:0]     hdr_size_ff,   hdr_size_in;

   logic [6:0]              len7;
   logic [CountWidth-1:0]   count_inc;
   logic [CountWidth-1:0]   ext_needed;
   logic [LengthWidth-1:0]  index_inc;
   logic [ByteWidth-1:0]    key_byte;
   logic                    last;

   assign len7       = held.stream_byte[6:0] & Len7Mask;
   assign count_inc  = count_ff + 3'd1;
   assign ext_needed = (hdr_size_ff == HdrExt16) ? Ext16Bytes : Ext64Bytes;
   assign index_inc  = index_ff + 64'd1;
   assign last       = (index_inc == length_ff);

   // Key byte 0 sits in the top byte and masks payload bytes 0, 4, 8 and so on.
   always_comb begin
      case (index_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // A result exists only for a payload byte.
   assign has_result            = held.valid && (phase_ff == PH_PAYLOAD);
   assign result.data_byte      = held.stream_byte ^ key_byte;
   assign result.last_of_frame  = last;
   assign result.payload_length = length_ff;
   assign result.header_length  = hdr_size_ff;

   // Next state of the frame parser for the held item.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      key_in      = key_ff;
      index_in    = index_ff;
      hdr_size_in = hdr_size_ff;
      case (phase_ff)
         PH_LEN: begin
            count_in = '0;
            key_in   = '0;
            if (len7 == LenExt16) begin
               length_in   = '0;
               hdr_size_in = HdrExt16;
               phase_in    = PH_EXT;
            end else if (len7 == LenExt64) begin
               length_in   = '0;
               hdr_size_in = HdrExt64;
               phase_in    = PH_EXT;
            end else begin
               length_in   = {57'd0, len7};
               hdr_size_in = HdrShort;
               phase_in    = PH_MASK;
            end
         end
         PH_EXT: begin
            length_in = {length_ff[LengthWidth-9:0], held.stream_byte};
            count_in  = count_inc;
            if (count_inc == ext_needed) begin
               count_in = '0;
               phase_in = PH_MASK;
            end
         end
         PH_MASK: begin
            key_in   = {key_ff[KeyWidth-9:0], held.stream_byte};
            count_in = count_inc;
            if (count_inc == KeyBytes) begin
               count_in = '0;
               index_in = '0;
               // A zero-length frame ends here without any result.
               phase_in = (length_ff == '0) ? PH_FIRST : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            index_in = index_inc;
            if (last) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            phase_in = PH_LEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         count_ff    <= '0;
         length_ff   <= '0;
         key_ff      <= '0;
         index_ff    <= '0;
         hdr_size_ff <= HdrShort;
      end else if (advance) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         key_ff      <= key_in;
         index_ff    <= index_in;
         hdr_size_ff <= hdr_size_in;
      end
   end

endmodule

>>> rtl/core/wsu_out_stage.sv
`timescale 1ns / 1ps

module wsu_out_stage
   import wsu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  result_type              result,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tlast
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // The register is free when empty or when its item is taken this cycle.
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = result_ff.last_of_frame;
   assign rsp_tdata  = {4'd0, result_ff.header_length, result_ff.payload_length,
                        result_ff.data_byte};

endmodule

>>> rtl/core/websocket_frame_unmasker_top.sv
`timescale 1ns / 1ps

// WebSocket frame unmasker.
// The req channel carries the received frame stream, one byte per item.
// For every payload byte the rsp channel delivers one item with the byte
// XORed with its mask key byte, the frame's payload length, the header
// length (6, 8 or 14) and tlast on the final payload byte of the frame.
// Header, extended length and mask key bytes, and whole zero-length frames,
// give no result item.
// A payload byte accepted on req is taken into the input register, passes
// the parser and is registered in the result register before it is
// offered on rsp.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single parser step between the two registers.
// Reset returns the parser to the first header byte and empties both
// registers. When the receiver stalls, the result register holds its item,
// the input register holds one more, and then req_tready falls.
module websocket_frame_unmasker_top
   import wsu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ByteWidth-1:0]    req_tdata,   // [7:0] stream_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // [7:0] data_byte,
                                                // [71:8] payload_length,
                                                // [75:72] header_length,
                                                // [79:76] zero
   output logic                    rsp_tlast
);

   held_item_type held;
   result_type    result;
   logic          has_result;
   logic          out_free;
   logic          advance;
   logic          load;

   // The held item moves on when it makes no result or the result register is free.
   assign advance = held.valid && (!has_result || out_free);
   assign load    = advance && has_result;

   wsu_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .held       (held)
   );

   wsu_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .held       (held),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   wsu_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
